// ===== hw/rtl/protobuf_block_header_extractor_defines.svh =====
// Assertion helpers shared by the RTL
`ifndef PROTOBUF_BLOCK_HEADER_EXTRACTOR_DEFINES_SVH
`define PROTOBUF_BLOCK_HEADER_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PBHX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PBHX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/pbhx_pkg.sv =====
package pbhx_pkg;

  localparam int unsigned FieldW   = 29;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned VarintCntW = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgGranularityId = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLatitudeId    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLongitudeId   = 2'd2;

  localparam logic [FieldW-1:0] RstGranularityId = 29'd17;
  localparam logic [FieldW-1:0] RstLatitudeId    = 29'd19;
  localparam logic [FieldW-1:0] RstLongitudeId   = 29'd20;

  localparam logic [31:0] DefaultGranularity = 32'd100;

  localparam logic [VarintCntW-1:0] VarintMaxBytes = 4'd10;

  // protobuf wire types
  localparam logic [2:0] WireVarint  = 3'd0;
  localparam logic [2:0] WireFixed64 = 3'd1;
  localparam logic [2:0] WireLenDelim = 3'd2;
  localparam logic [2:0] WireFixed32 = 3'd5;

  localparam logic [63:0] SkipFixed64 = 64'd8;
  localparam logic [63:0] SkipFixed32 = 64'd4;

  typedef struct packed {
    logic [FieldW-1:0] granularity_id;
    logic [FieldW-1:0] latitude_id;
    logic [FieldW-1:0] longitude_id;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] granularity;
    logic signed [63:0] latitude_offset;
    logic signed [63:0] longitude_offset;
    logic               stopped_early;
  } result_t;

endpackage

// ===== hw/rtl/pbhx_if.sv =====
interface pbhx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface pbhx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] granularity;
  logic signed [63:0] latitude_offset;
  logic signed [63:0] longitude_offset;
  logic               stopped_early;

  modport source (output valid, output granularity, output latitude_offset,
                  output longitude_offset, output stopped_early, input ready);
  modport sink   (input valid, input granularity, input latitude_offset,
                  input longitude_offset, input stopped_early, output ready);
endinterface

// ===== hw/rtl/pbhx_parser.sv =====
module pbhx_parser
  import pbhx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PhTag,
    PhValue,
    PhLen,
    PhSkip,
    PhStop
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [63:0]           acc_q, acc_d;
  logic [VarintCntW-1:0] cnt_q, cnt_d;
  logic [FieldW-1:0]     field_q, field_d;
  logic [63:0]           skip_q, skip_d;
  logic [31:0]           gran_q, gran_d;
  logic [63:0]           lat_q, lat_d;
  logic [63:0]           lon_q, lon_d;

  logic [VarintCntW-1:0] cnt_inc;
  logic [5:0]            shamt;
  logic [63:0]           acc_or;
  logic [63:0]           skip_dec;
  logic [2:0]            wire_type;

  function automatic logic [63:0] zigzag(input logic [63:0] v);
    return (v >> 1) ^ {64{v[0]}};
  endfunction

  // count stays below ten in varint phases, so 7*k fits six bits
  assign cnt_inc   = cnt_q + 1'b1;
  assign shamt     = 6'(7 * cnt_q);
  assign acc_or    = acc_q | (64'(byte_i[6:0]) << shamt);
  assign skip_dec  = skip_q - 64'(skip_q != '0);
  assign wire_type = acc_or[2:0];

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    field_d = field_q;
    skip_d  = skip_q;
    gran_d  = gran_q;
    lat_d   = lat_q;
    lon_d   = lon_q;

    unique case (phase_q)
      PhTag, PhValue, PhLen: begin
        if (byte_i[7]) begin
          if (cnt_inc >= VarintMaxBytes) begin
            // overlong varint
            phase_d = PhStop;
            acc_d   = '0;
            cnt_d   = '0;
          end else begin
            acc_d = acc_or;
            cnt_d = cnt_inc;
          end
        end else begin
          acc_d = '0;
          cnt_d = '0;
          unique case (phase_q)
            PhTag: begin
              field_d = acc_or[31:3];
              unique case (wire_type)
                WireVarint:   phase_d = PhValue;
                WireFixed64: begin
                  phase_d = PhSkip;
                  skip_d  = SkipFixed64;
                end
                WireLenDelim: phase_d = PhLen;
                WireFixed32: begin
                  phase_d = PhSkip;
                  skip_d  = SkipFixed32;
                end
                default:      phase_d = PhStop;
              endcase
            end
            PhValue: begin
              priority if (field_q == cfg_i.granularity_id) begin
                gran_d = acc_or[31:0];
              end else if (field_q == cfg_i.latitude_id) begin
                lat_d = zigzag(acc_or);
              end else if (field_q == cfg_i.longitude_id) begin
                lon_d = zigzag(acc_or);
              end
              phase_d = PhTag;
            end
            default: begin
              if (acc_or == '0) begin
                phase_d = PhTag;
              end else begin
                skip_d  = acc_or;
                phase_d = PhSkip;
              end
            end
          endcase
        end
      end
      PhSkip: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PhTag;
        end
      end
      default: ;
    endcase
  end

  // report values as updated by the last word itself
  assign res_o.granularity      = gran_d;
  assign res_o.latitude_offset  = lat_d;
  assign res_o.longitude_offset = lon_d;
  assign res_o.stopped_early    = (phase_d != PhTag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTag;
      acc_q   <= '0;
      cnt_q   <= '0;
      field_q <= '0;
      skip_q  <= '0;
      gran_q  <= DefaultGranularity;
      lat_q   <= '0;
      lon_q   <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PhTag;
        acc_q   <= '0;
        cnt_q   <= '0;
        field_q <= '0;
        skip_q  <= '0;
        gran_q  <= DefaultGranularity;
        lat_q   <= '0;
        lon_q   <= '0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        field_q <= field_d;
        skip_q  <= skip_d;
        gran_q  <= gran_d;
        lat_q   <= lat_d;
        lon_q   <= lon_d;
      end
    end
  end

endmodule

// ===== hw/rtl/pbhx_out_reg.sv =====
module pbhx_out_reg
  import pbhx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  result_t    res_i,
  output logic       can_load_o,
  pbhx_out_if.source out_o
);

  logic    valid_q;
  result_t res_q;

  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.granularity      = res_q.granularity;
  assign out_o.latitude_offset  = res_q.latitude_offset;
  assign out_o.longitude_offset = res_q.longitude_offset;
  assign out_o.stopped_early    = res_q.stopped_early;

endmodule

// ===== hw/rtl/protobuf_block_header_extractor.sv =====
// Channel   | Dir | Words                      | Payload
// ----------+-----+----------------------------+-----------------------------------
// in_ch_i   | in  | one message byte           | byte_value, last_byte
// out_ch_o  | out | one per last-flagged byte  | granularity, lat/lon offset, stopped
// cfg       | in  | register write, no readback| cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// One byte per cycle unless a last byte stalls: the parser updates its
// varint/skip state from the input register; a result is registered in the
// output register when its last byte steps the parser. Reset restores ids
// and granularity to defaults and zeroes offsets and parse state. Non-last
// bytes flow while a result waits; only last bytes stall on a pending word.
`include "protobuf_block_header_extractor_defines.svh"

module protobuf_block_header_extractor
  import pbhx_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [FieldW-1:0]  cfg_wdata_i,
  pbhx_in_if.sink            in_ch_i,
  pbhx_out_if.source         out_ch_o
);

  cfg_t       cfg_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       step;
  logic       can_load;
  logic       in_fire;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.granularity_id <= RstGranularityId;
      cfg_q.latitude_id    <= RstLatitudeId;
      cfg_q.longitude_id   <= RstLongitudeId;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGranularityId: cfg_q.granularity_id <= cfg_wdata_i;
        CfgLatitudeId:    cfg_q.latitude_id    <= cfg_wdata_i;
        CfgLongitudeId:   cfg_q.longitude_id   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign step           = s1_valid_q && (!s1_last_q || can_load);
  assign in_ch_i.ready  = !s1_valid_q || step;
  assign in_fire        = in_ch_i.valid && in_ch_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch_i.ready) begin
      s1_valid_q <= in_ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_ch_i.byte_value;
      s1_last_q <= in_ch_i.last_byte;
    end
  end

  pbhx_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .last_i (s1_last_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  pbhx_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && s1_last_q),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_ch_o)
  );

  `PBHX_ASSERT_NEXT(a_last_gives_result, step && s1_last_q, out_ch_o.valid, "last byte lost its result")
  `PBHX_ASSERT_NOW(a_no_overwrite, out_ch_o.valid && !out_ch_o.ready, !(step && s1_last_q), "pending result overwritten")
  `PBHX_ASSERT_NEXT(a_accept_held, in_fire, s1_valid_q, "accepted byte dropped")

endmodule
